FILE: hw/rtl/hufftw_pkg.sv
package hufftw_pkg;

   // node table geometry
   localparam int NODE_COUNT = 512;
   localparam int NODE_AW    = $clog2(NODE_COUNT);
   localparam int CHILD_W    = 10;
   localparam int ENTRY_W    = 2 * CHILD_W;

   // byte stream fields
   localparam int BYTE_BITS  = 8;
   localparam int CNT_W      = 4;
   localparam int VB_W       = 4;
   localparam int SYM_W      = 8;

   localparam logic [NODE_AW-1:0] ROOT_RESET = NODE_AW'(256);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RD_ROOT,
      ST_RD_POS,
      ST_WALK
   } state_type;

   typedef enum logic {
      REQ_LOAD   = 1'b0,
      REQ_DECODE = 1'b1
   } req_kind_type;

   // a child index at or beyond the table size means no child
   function automatic logic child_missing(input logic [CHILD_W-1:0] c);
      return c >= CHILD_W'(NODE_COUNT);
   endfunction

endpackage

FILE: hw/rtl/hufftw_ram.sv
module hufftw_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/huffman_tree_walk_decoder.sv
// Huffman tree-walk decoder. A load item (req_type 0) writes one node of the
// code tree, its left and right child indices, into a 512-entry node table
// held in a block RAM; a child index of 512 or more means no child. A
// decode item (req_type 1) carries one compressed byte, used MSB first; on a
// final byte only the low req_valid_bits bits count (0 means 8). Every bit
// steps the walk to the left (0) or right (1) child; reaching a leaf gives the
// low byte of its index as rsp_symbol and restarts at the root, a missing
// child gives rsp_bad_code with symbol 0 and restarts at the root. rsp_run_last
// marks the last result of a byte; a byte that completes no code gives no
// result. The walk position carries over between bytes unless the byte is
// final. A decode first reads the root entry and then the current node entry,
// then walks the used bits in order, with one RAM read per bit that reaches a
// child (each child address comes from the previous read), a return to the
// root after each leaf and a close of the byte at the end; it takes longer
// while rsp_stall holds results back. Results go through an output register,
// so the block returns to idle while the last result still waits.
// csr_root_index is written only while idle; it also moves the walk to the new
// root. Node table entries read before being written give undefined results.
module huffman_tree_walk_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   // requests
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_type,
   input  logic [hufftw_pkg::NODE_AW-1:0]       req_node_index,
   input  logic [hufftw_pkg::CHILD_W-1:0]       req_left_child,
   input  logic [hufftw_pkg::CHILD_W-1:0]       req_right_child,
   input  logic [hufftw_pkg::BYTE_BITS-1:0]     req_code_byte,
   input  logic                                 req_final_byte,
   input  logic [hufftw_pkg::VB_W-1:0]          req_valid_bits,
   // results
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [hufftw_pkg::SYM_W-1:0]         rsp_symbol,
   output logic                                 rsp_bad_code,
   output logic                                 rsp_run_last,
   // root register
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [hufftw_pkg::NODE_AW-1:0]       csr_root_index
);

   // control
   hufftw_pkg::state_type state_ff, state_in;
   logic [hufftw_pkg::NODE_AW-1:0]   root_ff, root_in;
   logic [hufftw_pkg::NODE_AW-1:0]   pos_ff, pos_in;
   logic [hufftw_pkg::CNT_W-1:0]     cnt_ff, cnt_in;      // bits left in the byte
   logic                             check_ff, check_in;  // RAM data is a fresh child
   logic                             from_root_ff, from_root_in;
   logic                             hold_v_ff, hold_v_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   // payload
   logic [hufftw_pkg::ENTRY_W-1:0]   root_entry_ff, root_entry_in;
   logic [hufftw_pkg::BYTE_BITS-1:0] shift_ff, shift_in;
   logic                             final_ff, final_in;
   logic [hufftw_pkg::CHILD_W-1:0]   child_ff, child_in;
   logic [hufftw_pkg::SYM_W-1:0]     hold_sym_ff, hold_sym_in;
   logic                             hold_bad_ff, hold_bad_in;
   logic [hufftw_pkg::SYM_W-1:0]     rsp_sym_ff, rsp_sym_in;
   logic                             rsp_bad_ff, rsp_bad_in;
   logic                             rsp_last_ff, rsp_last_in;

   // node table port
   logic                             ram_we;
   logic [hufftw_pkg::NODE_AW-1:0]   ram_waddr;
   logic [hufftw_pkg::ENTRY_W-1:0]   ram_wdata;
   logic                             ram_re;
   logic [hufftw_pkg::NODE_AW-1:0]   ram_raddr;
   logic [hufftw_pkg::ENTRY_W-1:0]   ram_rdata;

   // datapath terms
   logic                             req_acc, csr_acc, out_free, can_emit;
   logic                             part_byte;
   logic [hufftw_pkg::CNT_W-1:0]     n_bits, lead_skip;
   logic [hufftw_pkg::ENTRY_W-1:0]   entry;
   logic                             leaf_hit;
   logic [hufftw_pkg::CHILD_W-1:0]   next_child;
   logic                             next_miss;

   hufftw_ram #(
      .WIDTH (hufftw_pkg::ENTRY_W),
      .DEPTH (hufftw_pkg::NODE_COUNT)
   ) u_node_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign req_stall    = (state_ff != hufftw_pkg::ST_IDLE);
   assign csr_ready    = (state_ff == hufftw_pkg::ST_IDLE);
   assign req_acc      = req_valid && !req_stall;
   assign csr_acc      = csr_valid && csr_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_symbol   = rsp_sym_ff;
   assign rsp_bad_code = rsp_bad_ff;
   assign rsp_run_last = rsp_last_ff;

   // output register free this cycle; a new result may go out when the
   // held one can move there (or nothing is held)
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign can_emit = !hold_v_ff || out_free;

   // bits used by a decode item, left-aligned into the shifter
   assign part_byte = req_final_byte && (req_valid_bits != '0) &&
                      (req_valid_bits < hufftw_pkg::VB_W'(hufftw_pkg::BYTE_BITS));
   assign n_bits    = part_byte ? hufftw_pkg::CNT_W'(req_valid_bits)
                                : hufftw_pkg::CNT_W'(hufftw_pkg::BYTE_BITS);
   assign lead_skip = hufftw_pkg::CNT_W'(hufftw_pkg::BYTE_BITS) - n_bits;

   // current node entry: fresh child from the RAM, or the cached root entry
   assign entry    = (check_ff || !from_root_ff) ? ram_rdata : root_entry_ff;
   assign leaf_hit = check_ff &&
                     hufftw_pkg::child_missing(ram_rdata[hufftw_pkg::CHILD_W-1:0]) &&
                     hufftw_pkg::child_missing(
                        ram_rdata[hufftw_pkg::ENTRY_W-1:hufftw_pkg::CHILD_W]);
   assign next_child = shift_ff[hufftw_pkg::BYTE_BITS-1]
                       ? entry[hufftw_pkg::ENTRY_W-1:hufftw_pkg::CHILD_W]
                       : entry[hufftw_pkg::CHILD_W-1:0];
   assign next_miss  = hufftw_pkg::child_missing(next_child);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hufftw_pkg::ST_IDLE;
         root_ff      <= hufftw_pkg::ROOT_RESET;
         pos_ff       <= hufftw_pkg::ROOT_RESET;
         cnt_ff       <= '0;
         check_ff     <= 1'b0;
         from_root_ff <= 1'b0;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         root_ff      <= root_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         check_ff     <= check_in;
         from_root_ff <= from_root_in;
         hold_v_ff    <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      root_entry_ff <= root_entry_in;
      shift_ff      <= shift_in;
      final_ff      <= final_in;
      child_ff      <= child_in;
      hold_sym_ff   <= hold_sym_in;
      hold_bad_ff   <= hold_bad_in;
      rsp_sym_ff    <= rsp_sym_in;
      rsp_bad_ff    <= rsp_bad_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      root_in       = root_ff;
      pos_in        = pos_ff;
      cnt_in        = cnt_ff;
      check_in      = check_ff;
      from_root_in  = from_root_ff;
      hold_v_in     = hold_v_ff;
      root_entry_in = root_entry_ff;
      shift_in      = shift_ff;
      final_in      = final_ff;
      child_in      = child_ff;
      hold_sym_in   = hold_sym_ff;
      hold_bad_in   = hold_bad_ff;
      rsp_sym_in    = rsp_sym_ff;
      rsp_bad_in    = rsp_bad_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      ram_we    = 1'b0;
      ram_waddr = req_node_index;
      ram_wdata = {req_right_child, req_left_child};
      ram_re    = 1'b0;
      ram_raddr = pos_ff;

      case (state_ff)
         hufftw_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (req_type == hufftw_pkg::REQ_LOAD) begin
                  ram_we = 1'b1;
               end else begin
                  shift_in = req_code_byte << lead_skip;
                  cnt_in   = n_bits;
                  final_in = req_final_byte;
                  state_in = hufftw_pkg::ST_RD_ROOT;
               end
            end
            if (csr_acc) begin
               root_in = csr_root_index;
               pos_in  = csr_root_index;
            end
         end

         hufftw_pkg::ST_RD_ROOT: begin
            ram_re    = 1'b1;
            ram_raddr = root_ff;
            state_in  = hufftw_pkg::ST_RD_POS;
         end

         hufftw_pkg::ST_RD_POS: begin
            // root entry arrives while the current node is read
            ram_re        = 1'b1;
            ram_raddr     = pos_ff;
            root_entry_in = ram_rdata;
            check_in      = 1'b0;
            from_root_in  = 1'b0;
            state_in      = hufftw_pkg::ST_WALK;
         end

         hufftw_pkg::ST_WALK: begin
            if (leaf_hit) begin
               // leaf: queue its index, back to root next cycle
               if (can_emit) begin
                  if (hold_v_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_sym_in   = hold_sym_ff;
                     rsp_bad_in   = hold_bad_ff;
                     rsp_last_in  = 1'b0;
                  end
                  hold_v_in    = 1'b1;
                  hold_sym_in  = child_ff[hufftw_pkg::SYM_W-1:0];
                  hold_bad_in  = 1'b0;
                  check_in     = 1'b0;
                  from_root_in = 1'b1;
                  pos_in       = root_ff;
               end
            end else if (cnt_ff != '0) begin
               if (next_miss) begin
                  if (can_emit) begin
                     if (hold_v_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_sym_in   = hold_sym_ff;
                        rsp_bad_in   = hold_bad_ff;
                        rsp_last_in  = 1'b0;
                     end
                     hold_v_in    = 1'b1;
                     hold_sym_in  = '0;
                     hold_bad_in  = 1'b1;
                     check_in     = 1'b0;
                     from_root_in = 1'b1;
                     pos_in       = root_ff;
                     cnt_in       = cnt_ff - hufftw_pkg::CNT_W'(1);
                     shift_in     = shift_ff << 1;
                  end
               end else begin
                  if (check_ff) begin
                     pos_in = child_ff[hufftw_pkg::NODE_AW-1:0];
                  end
                  ram_re       = 1'b1;
                  ram_raddr    = next_child[hufftw_pkg::NODE_AW-1:0];
                  child_in     = next_child;
                  check_in     = 1'b1;
                  from_root_in = 1'b0;
                  cnt_in       = cnt_ff - hufftw_pkg::CNT_W'(1);
                  shift_in     = shift_ff << 1;
               end
            end else if (check_ff) begin
               // last bit landed on an inner node
               pos_in   = child_ff[hufftw_pkg::NODE_AW-1:0];
               check_in = 1'b0;
            end else begin
               // byte done: release the held result, if any, as the last one
               if (hold_v_ff) begin
                  if (out_free) begin
                     rsp_valid_in = 1'b1;
                     rsp_sym_in   = hold_sym_ff;
                     rsp_bad_in   = hold_bad_ff;
                     rsp_last_in  = 1'b1;
                     hold_v_in    = 1'b0;
                     state_in     = hufftw_pkg::ST_IDLE;
                     if (final_ff) begin
                        pos_in = root_ff;
                     end
                  end
               end else begin
                  state_in = hufftw_pkg::ST_IDLE;
                  if (final_ff) begin
                     pos_in = root_ff;
                  end
               end
            end
         end

         default: begin
            state_in = hufftw_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // a result is only held back while a byte is being walked
   assert property (@(posedge clock) disable iff (reset)
      hold_v_ff |-> (state_ff == hufftw_pkg::ST_WALK))
      else $error("held result outside walk");

   // a pending child check always belongs to a walk
   assert property (@(posedge clock) disable iff (reset)
      check_ff |-> (state_ff == hufftw_pkg::ST_WALK))
      else $error("child check outside walk");

   // bit count never exceeds one byte
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= hufftw_pkg::CNT_W'(hufftw_pkg::BYTE_BITS))
      else $error("bit count overflow");

   // bad codes carry symbol zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_sym_ff == '0))
      else $error("bad code with non-zero symbol");
`endif

endmodule

FILE: dv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODE_COUNT = hufftw_pkg::NODE_COUNT;
   localparam int NODE_AW    = hufftw_pkg::NODE_AW;
   localparam int CHILD_W    = hufftw_pkg::CHILD_W;
   localparam int ENTRY_W    = hufftw_pkg::ENTRY_W;
   localparam int BYTE_BITS  = hufftw_pkg::BYTE_BITS;
   localparam int VB_W       = hufftw_pkg::VB_W;
   localparam int SYM_W      = hufftw_pkg::SYM_W;

   // 512, like any other child value with bit 9 set, means "no child"
   localparam logic [CHILD_W-1:0] NO_CHILD = CHILD_W'(NODE_COUNT);
   // time for a byte to finish its walk and pass the output register, with margin
   localparam int DRAIN_CYCLES = 40;
   // long receiver hold-off, so that the block backs up into req_stall
   localparam int HOLD_CYCLES  = 300;
   // cycles with no item moved on any channel before giving up
   localparam int QUIET_LIMIT  = 2000;
   localparam int PHASE_COUNT  = 8;
   localparam int BYTES_PER_PHASE = 42;

   // one input item, as it goes onto the req_ ports
   typedef struct {
      hufftw_pkg::req_kind_type kind;
      logic [NODE_AW-1:0]     node;
      logic [CHILD_W-1:0]     left;
      logic [CHILD_W-1:0]     right;
      logic [BYTE_BITS-1:0]   code;
      logic                   fin;
      logic [VB_W-1:0]        vb;
   } code_item_type;

   // one decoded item, as it leaves on the rsp_ ports
   typedef struct {
      logic [SYM_W-1:0]       symbol;
      logic                   bad_code;
      logic                   run_last;
   } decoded_type;

   // Shadow of the node table, the walk and the root register, plus the
   // queue of symbols still owed by the block.
   class symbol_scoreboard;
      logic [ENTRY_W-1:0]  node_mem [NODE_COUNT];
      logic [NODE_AW-1:0]  root_pos = hufftw_pkg::ROOT_RESET;
      logic [NODE_AW-1:0]  walk_pos = hufftw_pkg::ROOT_RESET;
      decoded_type         expected_q [$];
      int                  failures = 0;

      // called once per accepted input item
      function void note_item(code_item_type it);
         decoded_type         found [BYTE_BITS];
         int                  n_used;
         int                  n_found;
         logic [NODE_AW-1:0]  pos;
         logic [ENTRY_W-1:0]  entry;
         logic [ENTRY_W-1:0]  target;
         logic [CHILD_W-1:0]  child;
         if (it.kind == hufftw_pkg::REQ_LOAD) begin
            node_mem[it.node] = {it.right, it.left};
            return;
         end
         // final byte: only the low vb bits count, 0 meaning all of them
         n_used = (it.fin && it.vb != 0 && it.vb < BYTE_BITS) ? int'(it.vb) : BYTE_BITS;
         n_found = 0;
         pos = walk_pos;
         for (int i = BYTE_BITS - n_used; i < BYTE_BITS; i++) begin
            entry = node_mem[pos];
            child = it.code[BYTE_BITS-1-i] ? entry[ENTRY_W-1:CHILD_W] : entry[CHILD_W-1:0];
            if (child >= NODE_COUNT) begin
               // stepped into a missing child: flag it, restart at root
               found[n_found] = '{symbol: '0, bad_code: 1'b1, run_last: 1'b0};
               n_found++;
               pos = root_pos;
            end else begin
               target = node_mem[child[NODE_AW-1:0]];
               if (target[CHILD_W-1:0] >= NODE_COUNT &&
                   target[ENTRY_W-1:CHILD_W] >= NODE_COUNT) begin
                  // leaf: its index, low byte only, is the symbol
                  found[n_found] = '{symbol: child[SYM_W-1:0], bad_code: 1'b0,
                                     run_last: 1'b0};
                  n_found++;
                  pos = root_pos;
               end else begin
                  pos = child[NODE_AW-1:0];
               end
            end
         end
         for (int j = 0; j < n_found; j++) begin
            if (j == n_found - 1)
               found[j].run_last = 1'b1;
            expected_q.push_back(found[j]);
         end
         // end of stream drops any partial code
         walk_pos = it.fin ? root_pos : pos;
      endfunction

      // called once per accepted result item
      function void check_item(logic [SYM_W-1:0] symbol, logic bad_code, logic run_last);
         decoded_type want;
         if (expected_q.size() == 0) begin
            $error("unexpected result: symbol %0d bad_code %0b run_last %0b",
                   symbol, bad_code, run_last);
            failures++;
            return;
         end
         want = expected_q.pop_front();
         if (want.symbol !== symbol) begin
            $error("symbol: expected %0d, got %0d", want.symbol, symbol);
            failures++;
         end
         if (want.bad_code !== bad_code) begin
            $error("bad_code: expected %0b, got %0b", want.bad_code, bad_code);
            failures++;
         end
         if (want.run_last !== run_last) begin
            $error("run_last: expected %0b, got %0b", want.run_last, run_last);
            failures++;
         end
      endfunction

      // root write also puts the walk back at the new root
      function void move_root(logic [NODE_AW-1:0] idx);
         root_pos = idx;
         walk_pos = idx;
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_type = 1'b0;
   logic [NODE_AW-1:0]    req_node_index = '0;
   logic [CHILD_W-1:0]    req_left_child = '0;
   logic [CHILD_W-1:0]    req_right_child = '0;
   logic [BYTE_BITS-1:0]  req_code_byte = '0;
   logic                  req_final_byte = 1'b0;
   logic [VB_W-1:0]       req_valid_bits = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [SYM_W-1:0]      rsp_symbol;
   logic                  rsp_bad_code;
   logic                  rsp_run_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [NODE_AW-1:0]    csr_root_index = '0;

   symbol_scoreboard      sb;
   int                    handshakes = 0;     // items moved on any channel
   int                    send_idle_pct = 0;
   int                    rsp_stall_pct = 0;
   bit                    hold_request = 1'b0;
   int                    written_q [$];      // loaded indices, for picking children

   huffman_tree_walk_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_node_index  (req_node_index),
      .req_left_child  (req_left_child),
      .req_right_child (req_right_child),
      .req_code_byte   (req_code_byte),
      .req_final_byte  (req_final_byte),
      .req_valid_bits  (req_valid_bits),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_symbol      (rsp_symbol),
      .rsp_bad_code    (rsp_bad_code),
      .rsp_run_last    (rsp_run_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_root_index  (csr_root_index)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Offer one item, with a random idle gap first. Valid stays high on
   // return, so back-to-back items need no gap cycle.
   task automatic send_item(input code_item_type it);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid       <= 1'b1;
      req_type        <= it.kind;
      req_node_index  <= it.node;
      req_left_child  <= it.left;
      req_right_child <= it.right;
      req_code_byte   <= it.code;
      req_final_byte  <= it.fin;
      req_valid_bits  <= it.vb;
      do @(posedge clock); while (req_stall);
      sb.note_item(it);
      handshakes++;
   endtask

   // Children must already be loaded (or be NO_CHILD), so that no walk ever
   // reads an entry that was never written.
   task automatic load_node(input int idx, input logic [CHILD_W-1:0] left,
                            input logic [CHILD_W-1:0] right);
      code_item_type it;
      it = '{kind: hufftw_pkg::REQ_LOAD, node: NODE_AW'(idx), left: left, right: right,
             code: BYTE_BITS'($urandom), fin: 1'($urandom), vb: VB_W'($urandom_range(8))};
      written_q.push_back(idx);
      send_item(it);
   endtask

   task automatic decode_byte(input int code, input bit fin, input int vb);
      code_item_type it;
      it = '{kind: hufftw_pkg::REQ_DECODE, node: NODE_AW'($urandom),
             left: CHILD_W'($urandom), right: CHILD_W'($urandom),
             code: BYTE_BITS'(code), fin: fin, vb: VB_W'(vb)};
      send_item(it);
   endtask

   // Root is only written with the block idle: every symbol in, then time
   // for a byte that owes no symbol to finish its walk.
   task automatic write_root(input int idx);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid      <= 1'b1;
      csr_root_index <= NODE_AW'(idx);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.move_root(NODE_AW'(idx));
      handshakes++;
   endtask

   // Result side: check what was taken at this edge, then choose the stall
   // for the next cycle. A hold-off request is counted down here.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            sb.check_item(rsp_symbol, rsp_bad_code, rsp_run_last);
            handshakes++;
         end
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // Watchdog: too long with nothing moving on any channel is a hang.
   initial begin : watchdog
      int seen;
      int quiet;
      seen  = 0;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (handshakes != seen) begin
            seen  = handshakes;
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int frontier [$];
      int a_idx;
      int b_idx;
      int idx;
      int n_leaves;
      logic [CHILD_W-1:0] l_child;
      logic [CHILD_W-1:0] r_child;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed part, root at its reset value of 256 ---
      // codes: 00 -> 300 (wide, symbol 44), 01 -> 65, 10 -> 0, 110 -> 511,
      // 111 -> missing child
      load_node(300, NO_CHILD, NO_CHILD);
      load_node(65,  NO_CHILD, NO_CHILD);
      load_node(0,   NO_CHILD, NO_CHILD);
      load_node(511, NO_CHILD, NO_CHILD);
      load_node(10,  300, 65);
      load_node(30,  511, NO_CHILD);
      load_node(20,  0, 30);
      load_node(256, 10, 20);
      decode_byte(8'h00, 1'b0, 0);     // four wide leaves
      decode_byte(8'hFF, 1'b0, 0);     // two bad codes, partial code carried over
      decode_byte(8'h1B, 1'b0, 5);     // valid bits ignored on a non-final byte
      decode_byte(8'h6D, 1'b1, 0);     // final, 0 means all eight bits
      decode_byte(8'hA5, 1'b1, 3);
      decode_byte(8'h3C, 1'b1, 8);
      decode_byte(8'h80, 1'b0, 0);
      decode_byte(8'h00, 1'b1, 1);     // one bit, partial code dropped, no item out
      decode_byte(8'h5A, 1'b1, 7);
      decode_byte(8'h96, 1'b0, 0);     // ends on a leaf, so no partial walk is left for the root write
      write_root(20);
      decode_byte(8'h96, 1'b0, 0);
      write_root(511);                 // root is a leaf: eight bad codes
      decode_byte(8'hC3, 1'b0, 0);
      write_root(0);
      decode_byte(8'h00, 1'b1, 8);
      write_root(256);

      // --- random part: a fresh tree per phase, then mostly random bytes ---
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 81;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 81;
            end
            default: begin
               send_idle_pct = 28;
               rsp_stall_pct = 28;
            end
         endcase

         // built bottom-up: leaves first, then joins of two loaded nodes;
         // now and then one branch is cut off to give a missing child
         frontier.delete();
         n_leaves = $urandom_range(2, 12);
         for (int k = 0; k < n_leaves; k++) begin
            idx = $urandom_range(NODE_COUNT - 1);
            load_node(idx, NO_CHILD, NO_CHILD);
            frontier.push_back(idx);
         end
         while (frontier.size() > 1) begin
            a_idx   = frontier.pop_front();
            b_idx   = frontier.pop_front();
            l_child = CHILD_W'(a_idx);
            r_child = ($urandom_range(7) == 0) ? NO_CHILD : CHILD_W'(b_idx);
            if ($urandom_range(1)) begin
               l_child = r_child;
               r_child = CHILD_W'(a_idx);
            end
            idx = $urandom_range(NODE_COUNT - 1);
            load_node(idx, l_child, r_child);
            frontier.push_back(idx);
         end
         write_root(frontier[0]);

         // back-pressure: receiver holds off while the sender keeps going
         if (phase == 4)
            hold_request = 1'b1;

         for (int k = 0; k < BYTES_PER_PHASE; k++) begin
            if ($urandom_range(9) == 0) begin
               // stray load over any entry, children already loaded or absent
               l_child = ($urandom_range(3) == 0) ? NO_CHILD :
                         CHILD_W'(written_q[$urandom_range(written_q.size() - 1)]);
               r_child = ($urandom_range(3) == 0) ? NO_CHILD :
                         CHILD_W'(written_q[$urandom_range(written_q.size() - 1)]);
               load_node($urandom_range(NODE_COUNT - 1), l_child, r_child);
            end else begin
               decode_byte($urandom_range(255), ($urandom_range(7) == 0),
                           $urandom_range(8));
            end
         end
      end

      // --- drain ---
      req_valid <= 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/hufftw_pkg.sv
hw/rtl/hufftw_ram.sv
hw/rtl/huffman_tree_walk_decoder.sv
dv/testbench.sv
